### hdl/bba_pkg.sv
// shared types and constants for the bitmap block allocator
package bba_pkg;

	// maximum number of blocks one allocation walk visits
	localparam int WALK_LIMIT = 32;

	// payload widths
	localparam int START_W = 5;
	localparam int LEN_W   = 6;
	localparam int INDEX_W = 5;
	localparam int COUNT_W = 6;

	// request kinds carried in tuser
	typedef enum logic [0:0] {
		REQ_MARK  = 1'b0,
		REQ_ALLOC = 1'b1
	} req_kind_t;

	// result status carried in tuser
	typedef enum logic [2:0] {
		ST_CLAIMED   = 3'd0,
		ST_SKIPPED   = 3'd1,
		ST_REFUSED   = 3'd2,
		ST_STORE_END = 3'd3,
		ST_MARKED    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		SEQ_CLEAR,
		SEQ_IDLE,
		SEQ_WALK
	} seq_state_t;

endpackage

### hdl/bitmap_block_allocator_top.sv
// top level of the bitmap block allocator: sequencer, used map memory and output register
//
// The block keeps one used bit per storage block in a small synchronous memory.
// After reset it runs a clearing pass, one entry at a time, that writes every
// bit to free; s_axis_tready stays low until that pass is done. A request is
// taken only while the sequencer is idle, one request at a time. A mark request,
// a refused start, an empty request or a start beyond the store is answered
// after the memory read of the start block and gives one transaction on the
// master side. An allocation walks the map one block per cycle while the output
// register is free, with a read-modify-write on the single memory port: the
// accept cycle also reads the start block, and each next block is read while
// the current one is checked, at most 32 visited blocks. Each visited block
// gives one result (claimed or skipped), so any back pressure on m_axis_tready
// stretches the walk. Results leave through an output register, so the next
// request is taken while the final result of the previous one still waits on
// the master side. The walk never goes past block NUM_BLOCKS-1; running out of
// store ends with a store end result at block 0.
module bitmap_block_allocator_top #(
	parameter int NUM_BLOCKS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// request stream
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [4:0] start_block, [10:5] run_length, rest zero
	input  logic [0:0]  s_axis_tuser,  // [0] req_type
	// result stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [4:0] block_index, rest zero
	output logic [2:0] m_axis_tuser,   // [2:0] status
	output logic       m_axis_tlast    // last result of a request
);

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int JW = $clog2(NUM_BLOCKS + 1);

	// sequencer state
	bba_pkg::seq_state_t state_q, state_d;
	logic [JW-1:0]                j_q, j_d;          // walk position, also clear counter
	logic [bba_pkg::COUNT_W-1:0]  visited_q, visited_d;
	logic [bba_pkg::COUNT_W-1:0]  claimed_q, claimed_d;
	logic                         first_q, first_d;

	// latched request
	bba_pkg::req_kind_t           kind_q;
	logic [bba_pkg::START_W-1:0]  start_q;
	logic [bba_pkg::LEN_W-1:0]    len_q;

	// memory port
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_data;
	logic [AW-1:0] rd_addr;
	logic          rd_data;

	// output register
	logic                         out_valid_q;
	logic [bba_pkg::INDEX_W-1:0]  out_idx_q, out_idx;
	bba_pkg::status_t             out_st_q, out_st;
	logic                         out_last_q, out_last;
	logic                         out_load;
	logic                         out_free;

	// helpers
	logic [bba_pkg::START_W-1:0]  in_start;
	logic [AW-1:0]                in_addr;
	logic                         in_accept;
	logic [JW-1:0]                j_next;
	logic [AW-1:0]                j_addr;
	logic [AW-1:0]                j_next_addr;
	logic [5:0]                   j_wide;
	logic [bba_pkg::COUNT_W-1:0]  claimed_inc;
	logic                         start_oos;
	logic                         walk_end;
	logic                         run_done;

	assign in_start  = s_axis_tdata[bba_pkg::START_W-1:0];
	assign in_addr   = (6'(in_start) < 6'(NUM_BLOCKS)) ? AW'(in_start) : '0;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	assign j_next      = j_q + JW'(1);
	assign j_addr      = (j_q < JW'(NUM_BLOCKS)) ? AW'(j_q) : '0;
	assign j_next_addr = (j_next < JW'(NUM_BLOCKS)) ? AW'(j_next) : '0;
	assign j_wide      = 6'(j_q);

	assign claimed_inc = claimed_q + bba_pkg::COUNT_W'(1);
	assign start_oos   = 6'(start_q) >= 6'(NUM_BLOCKS);
	assign walk_end    = (visited_q == bba_pkg::COUNT_W'(bba_pkg::WALK_LIMIT))
		|| (j_q == JW'(NUM_BLOCKS));
	assign run_done    = claimed_inc == len_q;

	assign out_free = !out_valid_q || m_axis_tready;

	bba_map_ram #(
		.DEPTH  (NUM_BLOCKS),
		.ADDR_W (AW)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bba_pkg::SEQ_CLEAR;
			j_q       <= '0;
			visited_q <= '0;
			claimed_q <= '0;
			first_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			j_q       <= j_d;
			visited_q <= visited_d;
			claimed_q <= claimed_d;
			first_q   <= first_d;
		end
	end

	// request payload, held for the whole walk
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q  <= bba_pkg::req_kind_t'(s_axis_tuser[0]);
			start_q <= in_start;
			len_q   <= s_axis_tdata[bba_pkg::START_W +: bba_pkg::LEN_W];
		end
	end

	// next state, memory access and result selection
	always_comb begin
		state_d       = state_q;
		j_d           = j_q;
		visited_d     = visited_q;
		claimed_d     = claimed_q;
		first_d       = first_q;
		wr_en         = 1'b0;
		wr_addr       = j_addr;
		wr_data       = 1'b1;
		rd_addr       = j_addr;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		out_idx       = j_wide[bba_pkg::INDEX_W-1:0];
		out_st        = bba_pkg::ST_CLAIMED;
		out_last      = 1'b0;
		case (state_q)
			bba_pkg::SEQ_CLEAR: begin
				// sweep the map to free, one entry a cycle
				wr_en   = 1'b1;
				wr_data = 1'b0;
				if (j_q == JW'(NUM_BLOCKS - 1)) begin
					j_d     = '0;
					state_d = bba_pkg::SEQ_IDLE;
				end else begin
					j_d = j_next;
				end
			end
			bba_pkg::SEQ_IDLE: begin
				s_axis_tready = 1'b1;
				rd_addr       = in_addr;
				if (in_accept) begin
					j_d       = JW'(in_start);
					visited_d = '0;
					claimed_d = '0;
					first_d   = 1'b1;
					state_d   = bba_pkg::SEQ_WALK;
				end
			end
			bba_pkg::SEQ_WALK: begin
				// rd_data holds the used bit of block j here
				if (out_free) begin
					out_load = 1'b1;
					if (first_q && start_oos) begin
						out_idx  = start_q;
						out_st   = bba_pkg::ST_STORE_END;
						out_last = 1'b1;
						state_d  = bba_pkg::SEQ_IDLE;
					end else if (first_q && kind_q == bba_pkg::REQ_MARK) begin
						wr_en    = 1'b1;
						out_idx  = start_q;
						out_st   = bba_pkg::ST_MARKED;
						out_last = 1'b1;
						state_d  = bba_pkg::SEQ_IDLE;
					end else if (first_q && rd_data) begin
						out_idx  = start_q;
						out_st   = bba_pkg::ST_REFUSED;
						out_last = 1'b1;
						state_d  = bba_pkg::SEQ_IDLE;
					end else if (first_q && len_q == '0) begin
						out_idx  = start_q;
						out_st   = bba_pkg::ST_EMPTY;
						out_last = 1'b1;
						state_d  = bba_pkg::SEQ_IDLE;
					end else if (walk_end) begin
						out_idx  = '0;
						out_st   = bba_pkg::ST_STORE_END;
						out_last = 1'b1;
						state_d  = bba_pkg::SEQ_IDLE;
					end else if (!rd_data) begin
						// free block: claim it
						wr_en     = 1'b1;
						claimed_d = claimed_inc;
						out_st    = bba_pkg::ST_CLAIMED;
						out_last  = run_done;
						if (run_done) begin
							state_d = bba_pkg::SEQ_IDLE;
						end else begin
							j_d       = j_next;
							visited_d = visited_q + bba_pkg::COUNT_W'(1);
							first_d   = 1'b0;
							rd_addr   = j_next_addr;
						end
					end else begin
						// used block inside the walk: skip it
						out_st    = bba_pkg::ST_SKIPPED;
						j_d       = j_next;
						visited_d = visited_q + bba_pkg::COUNT_W'(1);
						first_d   = 1'b0;
						rd_addr   = j_next_addr;
					end
				end
			end
			default: begin
				state_d = bba_pkg::SEQ_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= out_idx;
			out_st_q   <= out_st;
			out_last_q <= out_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_idx_q};
	assign m_axis_tuser  = out_st_q;
	assign m_axis_tlast  = out_last_q;

	// one request at a time: nothing new is taken right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready)
		else $error("request taken while a walk is in progress");

	// an allocation never writes a block that reads back as used
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == bba_pkg::SEQ_WALK && kind_q == bba_pkg::REQ_ALLOC) |-> !rd_data)
		else $error("allocation claimed a used block");

	// a result is never loaded over one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_valid_q) |-> m_axis_tready)
		else $error("pending result overwritten");

	// the walk never visits more than the walk limit
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bba_pkg::SEQ_WALK |-> visited_q <= bba_pkg::COUNT_W'(bba_pkg::WALK_LIMIT))
		else $error("walk ran past its limit");

endmodule

### hdl/bba_map_ram.sv
// single-bit used map memory, one write and one registered read port
module bba_map_ram #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic              wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic              rd_data
);

	logic mem_q [DEPTH];
	logic rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### tb/tb.sv
// self-checking testbench for the bitmap block allocator: directed table, random requests, scoreboard
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// store size under test, matches the block default
	localparam int NB          = 32;
	localparam int RAND_ITEMS  = 235;
	// long receiver hold-off, long enough to back the block up into its input
	localparam int HOLD_CYCLES = 300;
	// cycles with no transaction on either side before the run is abandoned;
	// the slowest correct stretch is the hold-off above or the clearing pass
	localparam int IDLE_LIMIT  = 3000;
	// waited after the drain so that a late stray result is still caught
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	// one result transaction as the block reports it
	typedef struct packed {
		logic [bba_pkg::INDEX_W-1:0] idx;
		bba_pkg::status_t            st;
		logic                        last;
	} blk_result_t;

	// one row of the directed table; typed rows carry their single answer
	typedef struct {
		bba_pkg::req_kind_t          kind;
		logic [bba_pkg::START_W-1:0] start;
		logic [bba_pkg::LEN_W-1:0]   len;
		bit                          typed;
		blk_result_t                 res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	bitmap_block_allocator_top #(
		.NUM_BLOCKS(NB)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// shadow copy of the used map and the results it predicts
	logic [NB-1:0] used_blocks;
	blk_result_t   walk_q[$];
	blk_result_t   expected_q[$];
	stim_row_t     dir_tab[$];

	int errors;
	int n_sent;
	int n_checked;
	int status_seen[8];
	int idle_cycles;
	int burst_left;
	// set by the sender, taken by the receiver process
	bit hold_pending;
	// forces back-to-back requests for a stretch of the random part
	bit no_gaps;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic blk_result_t mk_result(logic [bba_pkg::INDEX_W-1:0] idx,
			bba_pkg::status_t st, logic last);
		blk_result_t r;
		r.idx  = idx;
		r.st   = st;
		r.last = last;
		return r;
	endfunction

	// predicted behavior of one request: updates the shadow map, fills walk_q
	function automatic void walk_predict(bba_pkg::req_kind_t kind,
			logic [bba_pkg::START_W-1:0] start, logic [bba_pkg::LEN_W-1:0] len);
		int j;
		int visited;
		int claimed;
		walk_q.delete();
		// start beyond the store: nothing changes
		if (int'(start) >= NB) begin
			walk_q.push_back(mk_result(start, bba_pkg::ST_STORE_END, 1'b1));
			return;
		end
		if (kind == bba_pkg::REQ_MARK) begin
			used_blocks[start] = 1'b1;
			walk_q.push_back(mk_result(start, bba_pkg::ST_MARKED, 1'b1));
			return;
		end
		// used start is refused before the length is looked at
		if (used_blocks[start]) begin
			walk_q.push_back(mk_result(start, bba_pkg::ST_REFUSED, 1'b1));
			return;
		end
		if (len == '0) begin
			walk_q.push_back(mk_result(start, bba_pkg::ST_EMPTY, 1'b1));
			return;
		end
		claimed = 0;
		j = int'(start);
		for (visited = 0; visited < bba_pkg::WALK_LIMIT && j < NB; visited++) begin
			if (!used_blocks[j]) begin
				used_blocks[j] = 1'b1;
				claimed++;
				walk_q.push_back(mk_result(j[bba_pkg::INDEX_W-1:0], bba_pkg::ST_CLAIMED,
					claimed == int'(len)));
				if (claimed == int'(len))
					return;
			end else begin
				walk_q.push_back(mk_result(j[bba_pkg::INDEX_W-1:0], bba_pkg::ST_SKIPPED,
					1'b0));
			end
			j++;
		end
		// ran out of store: claimed blocks stay claimed
		walk_q.push_back(mk_result('0, bba_pkg::ST_STORE_END, 1'b1));
	endfunction

	function automatic stim_row_t dir_row(bba_pkg::req_kind_t kind, int start, int len,
			int typed, int idx, bba_pkg::status_t st, int last);
		stim_row_t r;
		r.kind  = kind;
		r.start = start[bba_pkg::START_W-1:0];
		r.len   = len[bba_pkg::LEN_W-1:0];
		r.typed = typed[0];
		r.res   = mk_result(idx[bba_pkg::INDEX_W-1:0], st, last[0]);
		return r;
	endfunction

	// random request: mostly short allocations so the map fills gradually
	function automatic stim_row_t random_row();
		stim_row_t r;
		int pick;
		r.typed = 1'b0;
		r.res   = mk_result('0, bba_pkg::ST_CLAIMED, 1'b0);
		r.kind  = ($urandom_range(0, 99) < 20) ? bba_pkg::REQ_MARK : bba_pkg::REQ_ALLOC;
		r.start = bba_pkg::START_W'($urandom_range(0, NB - 1));
		pick    = $urandom_range(0, 99);
		if (pick < 10)
			r.len = '0;
		else if (pick < 75)
			r.len = bba_pkg::LEN_W'($urandom_range(1, 3));
		else if (pick < 95)
			r.len = bba_pkg::LEN_W'($urandom_range(4, 31));
		else
			r.len = 6'd32;
		return r;
	endfunction

	// offer one request, wait for the transaction, then record its predicted results
	task automatic send_req(input stim_row_t row);
		int gap;
		if (burst_left == 0) begin
			if (no_gaps)
				gap = 0;
			else if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(4, 20);
			else
				gap = $urandom_range(0, 3);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= row.kind;
		s_axis_tdata  <= {5'b0, row.len, row.start};
		do @(posedge clk); while (!s_axis_tready);
		walk_predict(row.kind, row.start, row.len);
		if (row.typed)
			expected_q.push_back(row.res);
		else
			foreach (walk_q[i]) expected_q.push_back(walk_q[i]);
		n_sent++;
	endtask

	// sender stops offering until every outstanding result has come back
	task automatic pause_until_done();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	// stimulus: reset, directed table, random requests, drain
	initial begin : stim
		int i;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		arst_n        = 1'b0;
		used_blocks   = '0;
		burst_left    = 0;
		hold_pending  = 1'b0;
		no_gaps       = 1'b0;

		// empty requests at both ends of a fresh store
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC,  0,  0, 1,  0, bba_pkg::ST_EMPTY,   1));
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC, 31,  0, 1, 31, bba_pkg::ST_EMPTY,   1));
		// mark the top block, then mark it again while already used
		dir_tab.push_back(dir_row(bba_pkg::REQ_MARK,  31, 32, 1, 31, bba_pkg::ST_MARKED,  1));
		dir_tab.push_back(dir_row(bba_pkg::REQ_MARK,  31,  0, 1, 31, bba_pkg::ST_MARKED,  1));
		// used start refused, zero length too
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC, 31,  0, 1, 31, bba_pkg::ST_REFUSED, 1));
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC, 31, 24, 1, 31, bba_pkg::ST_REFUSED, 1));
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC,  0,  1, 1,  0, bba_pkg::ST_CLAIMED, 1));
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC,  0, 32, 1,  0, bba_pkg::ST_REFUSED, 1));
		dir_tab.push_back(dir_row(bba_pkg::REQ_MARK,   4,  5, 1,  4, bba_pkg::ST_MARKED,  1));
		dir_tab.push_back(dir_row(bba_pkg::REQ_MARK,   6,  1, 1,  6, bba_pkg::ST_MARKED,  1));
		// walk with skips over marked blocks
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC,  3,  3, 0,  0, bba_pkg::ST_CLAIMED, 0));
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC, 30,  1, 1, 30, bba_pkg::ST_CLAIMED, 1));
		// store end reached after skipping the top blocks
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC, 28, 32, 0,  0, bba_pkg::ST_CLAIMED, 0));
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC, 10,  2, 0,  0, bba_pkg::ST_CLAIMED, 0));
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC, 21, 12, 0,  0, bba_pkg::ST_CLAIMED, 0));
		dir_tab.push_back(dir_row(bba_pkg::REQ_MARK,  15, 63, 1, 15, bba_pkg::ST_MARKED,  1));
		dir_tab.push_back(dir_row(bba_pkg::REQ_ALLOC, 14,  2, 0,  0, bba_pkg::ST_CLAIMED, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[k]) send_req(dir_tab[k]);
		pause_until_done();

		for (i = 0; i < RAND_ITEMS; i++) begin
			// receiver backs off for a long stretch while requests keep coming
			if (i == 20)
				hold_pending = 1'b1;
			if (i == 110)
				pause_until_done();
			no_gaps = (i >= 140 && i < 180);
			send_req(random_row());
		end
		s_axis_tvalid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("checked %0d results from %0d requests (%0d directed, %0d random)",
			n_checked, n_sent, dir_tab.size(), n_sent - dir_tab.size());
		$display("statuses seen: %0d claimed, %0d skipped, %0d refused, %0d store end,",
			status_seen[bba_pkg::ST_CLAIMED], status_seen[bba_pkg::ST_SKIPPED],
			status_seen[bba_pkg::ST_REFUSED], status_seen[bba_pkg::ST_STORE_END]);
		$display("  %0d marked, %0d empty",
			status_seen[bba_pkg::ST_MARKED], status_seen[bba_pkg::ST_EMPTY]);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver: ready drawn at a rate that is redrawn for each stretch, plus one long hold-off
	initial begin : recv
		int pct;
		int left;
		int n;
		m_axis_tready = 1'b0;
		pct  = 100;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_axis_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
			end else begin
				if (left == 0) begin
					case ($urandom_range(0, 3))
						0: pct = 100;
						1: pct = 85;
						2: pct = 50;
						default: pct = 20;
					endcase
					left = $urandom_range(8, 64);
				end
				left--;
				m_axis_tready <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// scoreboard: each result transaction against the oldest expectation
	always @(posedge clk) begin : mon
		blk_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_checked++;
			status_seen[m_axis_tuser]++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: idx %0d status %0d last %0d",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				want = expected_q.pop_front();
				if (m_axis_tdata !== {3'b0, want.idx} || m_axis_tuser !== want.st ||
						m_axis_tlast !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("mismatch: expected idx %0d %s last %0d, %s %0d %0d %0d",
							want.idx, want.st.name(), want.last,
							"got idx/status/last", m_axis_tdata, m_axis_tuser,
							m_axis_tlast);
				end
			end
		end
	end

	// watchdog: no transaction on either side for too long ends the run
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		errors      = 0;
		n_sent      = 0;
		n_checked   = 0;
		idle_cycles = 0;
		foreach (status_seen[k]) status_seen[k] = 0;
	end

endmodule
